// ===== sv/ipt_pkg.sv =====
// Package for the IP packet trace-length block: record type, codes and shared helpers.
package ipt_pkg;

    // IP version codes (high nibble of the first byte).
    localparam logic [3:0] VER_IPV4 = 4'd4;
    localparam logic [3:0] VER_IPV6 = 4'd6;

    // Protocol numbers that get special handling.
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    // Fixed header sizes and length limits in bytes.
    localparam logic [5:0]  IPV6_HDR_LEN    = 6'd40;
    localparam logic [15:0] MIN_BUF_LEN     = 16'd20;
    localparam logic [16:0] TCP_MIN_HDR_LEN = 17'd20;
    localparam logic [16:0] UDP_HDR_LEN     = 17'd8;
    localparam logic [15:0] MAX_BYTE_COUNT  = 16'hFFFF;

    // Configuration port.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FTP_CONTROL_PORT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DNS_PORT         = 1'b1;
    localparam logic [15:0] FTP_PORT_RESET = 16'd21;
    localparam logic [15:0] DNS_PORT_RESET = 16'd53;

    // Entries in the queue between the capture and evaluation parts.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Everything the evaluation part needs to know about one finished packet.
    typedef struct packed {
        logic [15:0] byte_count;
        logic        count_overflow;
        logic [7:0]  version_byte;
        logic [15:0] length_field;
        logic [7:0]  protocol_number;
        logic [3:0]  transport_offset_nibble;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] udp_length_field;
    } t_pkt_rec;

    // IP header length in bytes; zero for an unknown version.
    function automatic logic [5:0] header_len(input logic [7:0] version_byte);
        logic [5:0] hl;
        hl = 6'd0;
        if (version_byte[7:4] == VER_IPV4) begin
            hl = {version_byte[3:0], 2'b00};
        end else if (version_byte[7:4] == VER_IPV6) begin
            hl = IPV6_HDR_LEN;
        end
        return hl;
    endfunction

endpackage

// ===== sv/ipt_front.sv =====
// Capture part: counts packet bytes, picks out header fields, emits one record per packet.
module ipt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_packet_byte,
    input  logic              i_last_byte,
    input  logic              i_full,
    output logic              o_push,
    output ipt_pkg::t_pkt_rec o_rec
);

    ipt_pkg::t_pkt_rec r_pkt;
    ipt_pkg::t_pkt_rec n_pkt;

    logic        accept;
    logic [15:0] idx;
    logic [7:0]  vb;
    logic [15:0] hl16;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_pkt = r_pkt;
        idx   = r_pkt.byte_count;
        // The first byte defines the version for its own capture as well.
        vb    = (idx == 16'd0) ? i_packet_byte : r_pkt.version_byte;
        hl16  = {10'd0, ipt_pkg::header_len(vb)};
        n_pkt.version_byte = vb;

        if (vb[7:4] == ipt_pkg::VER_IPV4) begin
            if (idx == 16'd2) n_pkt.length_field[15:8] = i_packet_byte;
            if (idx == 16'd3) n_pkt.length_field[7:0]  = i_packet_byte;
            if (idx == 16'd9) n_pkt.protocol_number    = i_packet_byte;
        end else if (vb[7:4] == ipt_pkg::VER_IPV6) begin
            if (idx == 16'd4) n_pkt.length_field[15:8] = i_packet_byte;
            if (idx == 16'd5) n_pkt.length_field[7:0]  = i_packet_byte;
            if (idx == 16'd6) n_pkt.protocol_number    = i_packet_byte;
        end

        // Transport fields sit at fixed offsets past the IP header.
        if (idx == hl16)          n_pkt.source_port[15:8]      = i_packet_byte;
        if (idx == hl16 + 16'd1)  n_pkt.source_port[7:0]       = i_packet_byte;
        if (idx == hl16 + 16'd2)  n_pkt.destination_port[15:8] = i_packet_byte;
        if (idx == hl16 + 16'd3)  n_pkt.destination_port[7:0]  = i_packet_byte;
        if (idx == hl16 + 16'd4)  n_pkt.udp_length_field[15:8] = i_packet_byte;
        if (idx == hl16 + 16'd5)  n_pkt.udp_length_field[7:0]  = i_packet_byte;
        if (idx == hl16 + 16'd12) n_pkt.transport_offset_nibble = i_packet_byte[7:4];

        // The count saturates and remembers that it did.
        if (idx == ipt_pkg::MAX_BYTE_COUNT) begin
            n_pkt.count_overflow = 1'b1;
        end else begin
            n_pkt.byte_count = idx + 16'd1;
        end
    end

    assign o_push = accept && i_last_byte;
    assign o_rec  = n_pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_pkt <= '0;
            end else begin
                r_pkt <= n_pkt;
            end
        end
    end

endmodule

// ===== sv/ipt_queue.sv =====
// Small FIFO of packet records between the capture and evaluation parts.
module ipt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ipt_pkg::t_pkt_rec i_rec,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output ipt_pkg::t_pkt_rec o_rec
);

    localparam int unsigned PTR_W = (ipt_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(ipt_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(ipt_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ipt_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ipt_pkg::QUEUE_DEPTH);

    ipt_pkg::t_pkt_rec r_mem [ipt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/ipt_back.sv =====
// Evaluation part: checks a packet record, picks the trace length, holds the result register.
module ipt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ipt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_q_valid,
    input  ipt_pkg::t_pkt_rec             i_rec,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [15:0]                   o_trace_length,
    output logic                          o_malformed
);

    logic [15:0] r_ftp_port;
    logic [15:0] r_dns_port;
    logic        r_valid;
    logic [15:0] r_trace_length;
    logic        r_malformed;

    logic [15:0] len;
    logic [3:0]  ver;
    logic [16:0] hl;
    logic [16:0] hl_tcp;
    logic [16:0] hl_udp;
    logic [15:0] total;
    logic        mal;
    logic [15:0] tlen;

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        len    = i_rec.byte_count;
        ver    = i_rec.version_byte[7:4];
        hl     = {11'd0, ipt_pkg::header_len(i_rec.version_byte)};
        hl_tcp = hl + {11'd0, i_rec.transport_offset_nibble, 2'b00};
        hl_udp = hl + ipt_pkg::UDP_HDR_LEN;
        total  = (ver == ipt_pkg::VER_IPV6) ?
                 i_rec.length_field + {10'd0, ipt_pkg::IPV6_HDR_LEN} : i_rec.length_field;
        mal    = 1'b0;
        tlen   = hl[15:0];

        if (i_rec.count_overflow || len <= ipt_pkg::MIN_BUF_LEN) begin
            mal = 1'b1;
        end else if (ver != ipt_pkg::VER_IPV4 && ver != ipt_pkg::VER_IPV6) begin
            mal = 1'b1;
        end else if (len < total || {1'b0, total} < hl) begin
            mal = 1'b1;
        end else begin
            case (i_rec.protocol_number)
                ipt_pkg::PROTO_TCP: begin
                    if ({1'b0, len} < hl + ipt_pkg::TCP_MIN_HDR_LEN ||
                        {1'b0, len} < hl_tcp) begin
                        mal = 1'b1;
                    end else if ({1'b0, total} == hl_tcp ||
                                 i_rec.source_port == r_ftp_port ||
                                 i_rec.destination_port == r_ftp_port) begin
                        tlen = total;
                    end else begin
                        tlen = hl_tcp[15:0];
                    end
                end
                ipt_pkg::PROTO_UDP: begin
                    if ({1'b0, len} < hl_udp ||
                        {1'b0, i_rec.udp_length_field} < ipt_pkg::UDP_HDR_LEN) begin
                        mal = 1'b1;
                    end else if (i_rec.source_port == r_dns_port ||
                                 i_rec.destination_port == r_dns_port) begin
                        tlen = total;
                    end else begin
                        tlen = hl_udp[15:0];
                    end
                end
                ipt_pkg::PROTO_ICMP, ipt_pkg::PROTO_ICMPV6: begin
                    if ({1'b0, len} < hl_udp) begin
                        mal = 1'b1;
                    end else begin
                        tlen = hl_udp[15:0];
                    end
                end
                default: begin
                    tlen = hl[15:0];
                end
            endcase
        end
        if (mal) begin
            tlen = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ftp_port <= ipt_pkg::FTP_PORT_RESET;
            r_dns_port <= ipt_pkg::DNS_PORT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ipt_pkg::CFG_FTP_CONTROL_PORT: r_ftp_port <= i_cfg_data;
                ipt_pkg::CFG_DNS_PORT:         r_dns_port <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_trace_length <= tlen;
            r_malformed    <= mal;
        end
    end

    assign o_valid        = r_valid;
    assign o_trace_length = r_trace_length;
    assign o_malformed    = r_malformed;

endmodule

// ===== sv/ip_packet_trace_length_core.sv =====
// Top level of the IP packet trace-length block.
//
// Usage: the bytes of one IPv4 or IPv6 packet enter on the input channel
// (i_valid / o_ready), one byte per transfer, with i_last_byte set on the
// final byte of the buffer. For each packet one result leaves on the output
// channel (o_valid / i_ready): the number of leading bytes to trace and a
// malformed flag, with a trace length of zero when a check failed.
// Configuration (FTP control port, DNS port) is written through i_cfg_we,
// i_cfg_index and i_cfg_data while no packet is in flight.
//
// Throughput is one byte per cycle while o_ready is high: the capture part
// updates its field registers in the cycle a byte is transferred. After the
// transfer of the last byte, the packet record is first placed in the
// two-entry queue, and the evaluation part then checks it and loads the
// output register. When the receiver stalls, the output register holds
// its result and the queue takes up to two more finished packets; o_ready
// falls only once the queue is full.
// The synchronous, active-low reset empties the queue and the output
// register, clears the capture state and restores the port registers to 21
// and 53.
module ip_packet_trace_length_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_packet_byte,
    input  logic                          i_last_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [15:0]                   o_trace_length,
    output logic                          o_malformed,
    input  logic                          i_cfg_we,
    input  logic [ipt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    // Records of finished packets travel from the capture part to the queue,
    // and from the queue to the evaluation part.
    ipt_pkg::t_pkt_rec push_rec;
    ipt_pkg::t_pkt_rec pop_rec;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;

    ipt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_packet_byte (i_packet_byte),
        .i_last_byte   (i_last_byte),
        .i_full        (q_full),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    ipt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_rec   (pop_rec)
    );

    ipt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_rec          (pop_rec),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_trace_length (o_trace_length),
        .o_malformed    (o_malformed)
    );

endmodule

// ===== sv/ipt_checker.sv =====
// Port-level checker for the IP packet trace-length block, bound to the top level.
module ipt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_trace_length,
    input logic        o_malformed
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_trace_length) && $stable(o_malformed))
        else $error("result changed while stalled");

    // A malformed packet always reports a zero trace length.
    a_mal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_malformed |-> o_trace_length == 16'd0)
        else $error("malformed result with nonzero length");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A result rising from idle is preceded by a last-byte transfer.
    a_rise_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_last_byte, 2))
        else $error("result without a preceding last byte");

endmodule

bind ip_packet_trace_length_core ipt_checker u_ipt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_last_byte    (i_last_byte),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_trace_length (o_trace_length),
    .o_malformed    (o_malformed)
);
